// ----- rtl/wake_slot_backoff_scheduler_defines.svh -----
// Assertion macros used by the checker file.
`ifndef WAKE_SLOT_BACKOFF_SCHEDULER_DEFINES_SVH
`define WAKE_SLOT_BACKOFF_SCHEDULER_DEFINES_SVH

// Check outside reset.
`define WSBS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check at every edge, reset included.
`define WSBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/wsbs_pkg.sv -----
package wsbs_pkg;

    localparam logic [16:0] SLOT_MOD        = 17'd119999;
    localparam int unsigned RECIP_SHIFT     = 48;
    localparam int unsigned Q_W             = 64 - RECIP_SHIFT;
    localparam logic [31:0] SLOT_RECIP      = 32'((64'd1 << RECIP_SHIFT) / 64'd119999);
    localparam logic [9:0]  MS_TO_US        = 10'd1000;
    localparam logic [23:0] ID_STEP_US      = 24'd15000000;
    localparam logic [3:0]  FAIL_SAT        = 4'd10;
    localparam logic [3:0]  RESLOT_AT       = 4'd3;
    localparam logic [3:0]  SHIFT_CAP       = 4'd7;
    localparam logic [16:0] BACKOFF_BASE_MS = 17'd1000;
    localparam logic [16:0] BACKOFF_CAP_MS  = 17'd120000;

    localparam int unsigned SUM_W           = 33;
    localparam int unsigned US_W            = 27;
    localparam logic [SUM_W-1:0] SLEEP_MIN_US = 33'd30000000;
    localparam logic [SUM_W-1:0] SLEEP_MAX_US = 33'd1200000000;

    localparam logic [7:0]  NODE_ID_RESET     = 8'd1;
    localparam logic [30:0] BASE_PERIOD_RESET = 31'd300000000;

    typedef enum logic [0:0] {
        CFG_NODE_ID     = 1'b0,
        CFG_BASE_PERIOD = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_OK    = 2'd0,
        KIND_FAIL  = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [5:0]  pad;
        logic [31:0] random_word;
        logic [1:0]  kind;
    } in_data_t;

    typedef struct packed {
        logic [1:0]  pad;
        logic        reslotted;
        logic [3:0]  failure_count;
        logic [16:0] retry_delay_ms;
        logic [16:0] slot_ms;
        logic [30:0] sleep_us;
    } out_data_t;

    function automatic logic [16:0] retry_delay_ms_of(input logic [3:0] cnt);
        logic [3:0]  sh;
        logic [16:0] val;
        begin
            sh  = (cnt - 4'd1 > SHIFT_CAP) ? SHIFT_CAP : cnt - 4'd1;
            val = BACKOFF_BASE_MS << sh;
            if (cnt == 4'd0)
            begin
                val = 17'd0;
            end
            else if (val > BACKOFF_CAP_MS)
            begin
                val = BACKOFF_CAP_MS;
            end
            return val;
        end
    endfunction

    function automatic logic [US_W-1:0] backoff_us_of(input logic [3:0] cnt);
        logic [US_W-1:0] prod;
        begin
            prod = US_W'(retry_delay_ms_of(cnt)) * US_W'(MS_TO_US);
            return prod;
        end
    endfunction

endpackage

// ----- rtl/wsbs_slot_mod.sv -----
module wsbs_slot_mod (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] rnd,
    output logic [16:0] cand
);

    logic [63:0]                   prod;
    logic [wsbs_pkg::Q_W-1:0]      q_reg;
    logic [31:0]                   rnd1_reg;
    logic [31:0]                   qm_reg;
    logic [31:0]                   rnd2_reg;
    logic [32:0]                   qm_next;
    logic [31:0]                   rem;
    logic [17:0]                   rem_fix;
    logic [16:0]                   cand_reg;
    logic [16:0]                   cand_next;

    assign prod    = 64'(rnd) * 64'(wsbs_pkg::SLOT_RECIP);
    assign qm_next = 33'(q_reg) * 33'(wsbs_pkg::SLOT_MOD);
    assign rem     = rnd2_reg - qm_reg;

    always_comb
    begin
        rem_fix = rem[17:0];
        if (rem_fix >= 18'(wsbs_pkg::SLOT_MOD))
        begin
            rem_fix = rem_fix - 18'(wsbs_pkg::SLOT_MOD);
        end
        cand_next = rem_fix[16:0] + 17'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg    <= prod[63:wsbs_pkg::RECIP_SHIFT];
            rnd1_reg <= rnd;
            qm_reg   <= qm_next[31:0];
            rnd2_reg <= rnd1_reg;
            cand_reg <= cand_next;
        end
    end

    assign cand = cand_reg;

endmodule

// ----- rtl/wake_slot_backoff_scheduler.sv -----
// Each input transfer gives one matching output on m_tvalid, in order.
// Throughput: one item per cycle; the failure count and phase slot update in a single
// stage, and the slot modulo runs as a three-stage reciprocal multiply ahead of it.
// A low m_tready with a full output register freezes every stage.
// Reset clears all valid bits, the failure count and the slot, and loads the
// register defaults (node_id 1, base_period_us 300000000).
module wake_slot_backoff_scheduler (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  wsbs_pkg::in_data_t  s_tdata,   // kind[1:0], random_word[33:2], zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output wsbs_pkg::out_data_t m_tdata,   // sleep_us[30:0], slot_ms[47:31],
                                           // retry_delay_ms[64:48], failure_count[68:65],
                                           // reslotted[69], zero pad
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [30:0]         cfg_data
);

    localparam int unsigned STAGES = 8;
    localparam int unsigned KIND_STAGES = 5;

    logic                    advance;
    logic [STAGES-1:0]       v_reg;
    wsbs_pkg::kind_t         kind_reg [KIND_STAGES];
    logic [31:0]             rnd_reg;
    logic [16:0]             cand;

    logic [7:0]              node_id_reg;
    logic [30:0]             base_reg;
    logic [7:0]              id_steps;
    logic [wsbs_pkg::SUM_W-1:0] cfg_off_reg;
    logic [wsbs_pkg::SUM_W-1:0] cfg_off_next;

    logic [16:0]             cand4_reg;
    logic [wsbs_pkg::US_W-1:0] cand_us_reg;

    logic [3:0]              fail_cnt_reg;
    logic [3:0]              fail_cnt_next;
    logic [3:0]              cnt_upd;
    logic [16:0]             slot_reg;
    logic [16:0]             slot_next;
    logic [wsbs_pkg::US_W-1:0] slot_us_reg;
    logic [wsbs_pkg::US_W-1:0] slot_us_next;
    logic                    reslot;

    logic [16:0]             s5_slot_reg;
    logic [16:0]             s5_bk_ms_reg;
    logic [3:0]              s5_cnt_reg;
    logic                    s5_reslot_reg;
    logic [wsbs_pkg::US_W-1:0] s5_slot_us_reg;
    logic [wsbs_pkg::US_W-1:0] s5_bk_us_reg;

    logic [wsbs_pkg::SUM_W-1:0] sum_reg;
    logic [wsbs_pkg::SUM_W-1:0] sum_next;
    logic [16:0]             s6_slot_reg;
    logic [16:0]             s6_bk_ms_reg;
    logic [3:0]              s6_cnt_reg;
    logic                    s6_reslot_reg;

    logic [wsbs_pkg::SUM_W-1:0] sleep_clamped;
    wsbs_pkg::out_data_t     out_reg;
    wsbs_pkg::out_data_t     out_next;

    assign advance   = !v_reg[STAGES-1] || m_tready;
    assign s_tready  = advance;
    assign m_tvalid  = v_reg[STAGES-1];
    assign m_tdata   = out_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[STAGES-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg <= wsbs_pkg::NODE_ID_RESET;
            base_reg    <= wsbs_pkg::BASE_PERIOD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (wsbs_pkg::cfg_index_t'(cfg_index))
                wsbs_pkg::CFG_NODE_ID:     node_id_reg <= cfg_data[7:0];
                wsbs_pkg::CFG_BASE_PERIOD: base_reg    <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        id_steps     = (node_id_reg == 8'd0) ? 8'd0 : node_id_reg - 8'd1;
        cfg_off_next = wsbs_pkg::SUM_W'(base_reg)
                     + wsbs_pkg::SUM_W'(id_steps) * wsbs_pkg::SUM_W'(wsbs_pkg::ID_STEP_US);
    end

    always_ff @(posedge clk)
    begin
        cfg_off_reg <= cfg_off_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rnd_reg     <= s_tdata.random_word;
            kind_reg[0] <= wsbs_pkg::kind_t'(s_tdata.kind);
            for (int i = 1; i < KIND_STAGES; i++)
            begin
                kind_reg[i] <= kind_reg[i-1];
            end
        end
    end

    wsbs_slot_mod u_slot_mod (
        .clk  (clk),
        .en   (advance),
        .rnd  (rnd_reg),
        .cand (cand)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cand4_reg   <= cand;
            cand_us_reg <= wsbs_pkg::US_W'(cand) * wsbs_pkg::US_W'(wsbs_pkg::MS_TO_US);
        end
    end

    always_comb
    begin
        unique case (kind_reg[KIND_STAGES-1])
            wsbs_pkg::KIND_OK:   cnt_upd = 4'd0;
            wsbs_pkg::KIND_FAIL: cnt_upd = (fail_cnt_reg >= wsbs_pkg::FAIL_SAT)
                                         ? wsbs_pkg::FAIL_SAT : fail_cnt_reg + 4'd1;
            default:             cnt_upd = fail_cnt_reg;
        endcase
        reslot        = (slot_reg == 17'd0) || (cnt_upd >= wsbs_pkg::RESLOT_AT);
        slot_next     = reslot ? cand4_reg : slot_reg;
        slot_us_next  = reslot ? cand_us_reg : slot_us_reg;
        fail_cnt_next = (cnt_upd >= wsbs_pkg::RESLOT_AT) ? 4'd0 : cnt_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_cnt_reg <= 4'd0;
            slot_reg     <= 17'd0;
            slot_us_reg  <= '0;
        end
        else if (advance && v_reg[KIND_STAGES-1])
        begin
            fail_cnt_reg <= fail_cnt_next;
            slot_reg     <= slot_next;
            slot_us_reg  <= slot_us_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s5_slot_reg    <= slot_next;
            s5_slot_us_reg <= slot_us_next;
            s5_cnt_reg     <= fail_cnt_next;
            s5_reslot_reg  <= reslot;
            s5_bk_ms_reg   <= wsbs_pkg::retry_delay_ms_of(fail_cnt_next);
            s5_bk_us_reg   <= wsbs_pkg::backoff_us_of(fail_cnt_next);
        end
    end

    assign sum_next = cfg_off_reg
                    + wsbs_pkg::SUM_W'(s5_slot_us_reg)
                    + wsbs_pkg::SUM_W'(s5_bk_us_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg       <= sum_next;
            s6_slot_reg   <= s5_slot_reg;
            s6_bk_ms_reg  <= s5_bk_ms_reg;
            s6_cnt_reg    <= s5_cnt_reg;
            s6_reslot_reg <= s5_reslot_reg;
        end
    end

    always_comb
    begin
        priority if (sum_reg < wsbs_pkg::SLEEP_MIN_US)
        begin
            sleep_clamped = wsbs_pkg::SLEEP_MIN_US;
        end
        else if (sum_reg > wsbs_pkg::SLEEP_MAX_US)
        begin
            sleep_clamped = wsbs_pkg::SLEEP_MAX_US;
        end
        else
        begin
            sleep_clamped = sum_reg;
        end
        out_next                = '0;
        out_next.sleep_us       = sleep_clamped[30:0];
        out_next.slot_ms        = s6_slot_reg;
        out_next.retry_delay_ms = s6_bk_ms_reg;
        out_next.failure_count  = s6_cnt_reg;
        out_next.reslotted      = s6_reslot_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- rtl/wsbs_checker.sv -----
`include "wake_slot_backoff_scheduler_defines.svh"

module wsbs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input wsbs_pkg::out_data_t m_tdata
);

    `WSBS_ASSERT(a_sleep_range, clk, rst_n,
        m_tvalid |-> (m_tdata.sleep_us >= 31'(wsbs_pkg::SLEEP_MIN_US)
                      && m_tdata.sleep_us <= 31'(wsbs_pkg::SLEEP_MAX_US)),
        "sleep_us out of range")
    `WSBS_ASSERT(a_slot_range, clk, rst_n,
        m_tvalid |-> (m_tdata.slot_ms != 17'd0
                      && m_tdata.slot_ms < wsbs_pkg::SLOT_MOD + 17'd1),
        "slot_ms out of range")
    `WSBS_ASSERT(a_backoff_count, clk, rst_n,
        (m_tvalid && m_tdata.failure_count == 4'd0) |-> (m_tdata.retry_delay_ms == 17'd0),
        "backoff without failures")
    `WSBS_ASSERT(a_hold, clk, rst_n,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)),
        "stalled output changed")
    `WSBS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !m_tvalid, "output valid in reset")

endmodule

bind wake_slot_backoff_scheduler wsbs_checker u_wsbs_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import wsbs_pkg::*;

    localparam logic [1:0]  KIND_RSVD    = 2'd3;
    localparam logic [63:0] SLOT_SPAN    = 64'd119999;
    localparam logic [63:0] US_PER_MS    = 64'd1000;
    localparam logic [63:0] NODE_STEP_US = 64'd15000000;
    localparam logic [63:0] BO_LIMIT_MS  = 64'd120000;
    localparam logic [63:0] WAKE_MIN_US  = 64'd30000000;
    localparam logic [63:0] WAKE_MAX_US  = 64'd1200000000;
    localparam logic [3:0]  FAIL_CEIL    = 4'd10;
    localparam logic [3:0]  RESLOT_FAILS = 4'd3;
    localparam logic [3:0]  MAX_SHIFT    = 4'd7;
    localparam int          PHASES       = 6;
    localparam int          PHASE_ITEMS  = 217;

    class wake_sched_tracker;
        logic [7:0]  node_id_r = 8'd1;
        logic [30:0] base_us   = 31'd300000000;
        logic [3:0]  fails     = 4'd0;
        logic [16:0] slot_r    = 17'd0;
        out_data_t   wake_q[$];
        int          err_cnt   = 0;

        function void set_reg(cfg_index_t idx, logic [30:0] v);
            if (idx == CFG_NODE_ID)
            begin
                node_id_r = v[7:0];
            end
            else
            begin
                base_us = v;
            end
        endfunction

        function void take_report(in_data_t d);
            out_data_t   exp_v;
            logic [63:0] bo;
            logic [63:0] id_steps;
            logic [63:0] total;
            logic [3:0]  sh;
            exp_v = '0;
            if (d.kind == KIND_OK)
            begin
                fails = 4'd0;
            end
            else if (d.kind == KIND_FAIL)
            begin
                fails = (fails >= FAIL_CEIL) ? FAIL_CEIL : fails + 4'd1;
            end
            if (slot_r == 17'd0 || fails >= RESLOT_FAILS)
            begin
                slot_r = 17'((64'(d.random_word) % SLOT_SPAN) + 64'd1);
                exp_v.reslotted = 1'b1;
                if (fails >= RESLOT_FAILS)
                begin
                    fails = 4'd0;
                end
            end
            bo = 64'd0;
            if (fails != 4'd0)
            begin
                sh = (fails - 4'd1 > MAX_SHIFT) ? MAX_SHIFT : fails - 4'd1;
                bo = US_PER_MS << sh;
                if (bo > BO_LIMIT_MS)
                begin
                    bo = BO_LIMIT_MS;
                end
            end
            id_steps = (node_id_r != 8'd0) ? 64'(node_id_r) - 64'd1 : 64'd0;
            total = 64'(base_us) + id_steps * NODE_STEP_US + 64'(slot_r) * US_PER_MS
                  + bo * US_PER_MS;
            if (total < WAKE_MIN_US)
            begin
                total = WAKE_MIN_US;
            end
            if (total > WAKE_MAX_US)
            begin
                total = WAKE_MAX_US;
            end
            exp_v.sleep_us       = total[30:0];
            exp_v.slot_ms        = slot_r;
            exp_v.retry_delay_ms = bo[16:0];
            exp_v.failure_count  = fails;
            wake_q.push_back(exp_v);
        endfunction

        function void cmp(string nm, logic [63:0] e, logic [63:0] a);
            if (e !== a)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                begin
                    $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, nm, e, a);
                end
            end
        endfunction

        function void match_wake(out_data_t a);
            out_data_t e;
            if (wake_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                begin
                    $display("%0t: unexpected result, sleep_us %0d", $realtime, a.sleep_us);
                end
                return;
            end
            e = wake_q.pop_front();
            cmp("sleep_us", 64'(e.sleep_us), 64'(a.sleep_us));
            cmp("slot_ms", 64'(e.slot_ms), 64'(a.slot_ms));
            cmp("retry_delay_ms", 64'(e.retry_delay_ms), 64'(a.retry_delay_ms));
            cmp("failure_count", 64'(e.failure_count), 64'(a.failure_count));
            cmp("reslotted", 64'(e.reslotted), 64'(a.reslotted));
        endfunction

        function int pending();
            return wake_q.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b1;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    in_data_t    s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    out_data_t   m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [30:0] cfg_data  = '0;

    logic        no_idle   = 1'b0;
    logic [7:0]  rx_tick   = '0;
    logic [1:0]  rx_mode   = '0;
    logic [15:0] rx_pat    = 16'hFFFF;

    wake_sched_tracker board = new();

    wake_slot_backoff_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                board.match_wake(m_tdata);
            end
            if (s_tvalid && s_tready)
            begin
                board.take_report(s_tdata);
            end
            if (cfg_valid && cfg_ready)
            begin
                board.set_reg(cfg_index_t'(cfg_index), cfg_data);
            end
        end
    end

    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 8'd1;
        if (rx_tick[5:0] == 6'd0)
        begin
            rx_mode <= 2'($urandom_range(0, 3));
            rx_pat  <= 16'($urandom);
        end
        if (!rst_n || no_idle)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            case (rx_mode)
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
                2'd2:    m_tready <= rx_pat[rx_tick[3:0]];
                default: m_tready <= (rx_tick[4:0] == 5'd0);
            endcase
        end
    end

    task automatic send_report(logic [1:0] k, logic [31:0] rnd);
        @(negedge clk);
        s_tvalid            = 1'b1;
        s_tdata             = '0;
        s_tdata.kind        = k;
        s_tdata.random_word = rnd;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic hold_off(int n);
        if (n > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain_wakes();
        hold_off(1);
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(cfg_index_t idx, logic [30:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_schedule(logic [30:0] node, logic [30:0] base);
        drain_wakes();
        write_reg(CFG_NODE_ID, node);
        write_reg(CFG_BASE_PERIOD, base);
    endtask

    task automatic directed_report(logic [1:0] k, logic [31:0] rnd);
        send_report(k, rnd);
        hold_off($urandom_range(0, 2));
    endtask

    task automatic pick_report(output logic [1:0] k, output logic [31:0] rnd);
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 6)
        begin
            k = KIND_OK;
        end
        else if (r < 12)
        begin
            k = KIND_FAIL;
        end
        else if (r < 15)
        begin
            k = KIND_ABORT;
        end
        else
        begin
            k = KIND_RSVD;
        end
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            rnd = 32'(SLOT_SPAN * 64'($urandom_range(0, 35791)));
            if ($urandom_range(0, 1) != 0)
            begin
                rnd = rnd + 32'(SLOT_SPAN - 64'd1);
            end
        end
        else if (r == 1)
        begin
            rnd = ($urandom_range(0, 1) != 0) ? 32'hFFFFFFFF : 32'h0;
        end
        else
        begin
            rnd = $urandom;
        end
    endtask

    function automatic logic [30:0] pick_node();
        case ($urandom_range(0, 5))
            0:       return 31'd0;
            1:       return 31'd1;
            2:       return 31'd2;
            3:       return 31'd255;
            4:       return 31'($urandom_range(0, 255));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [30:0] pick_base();
        case ($urandom_range(0, 6))
            0:       return 31'd0;
            1:       return 31'd1200000000;
            2:       return 31'h7FFFFFFF;
            3:       return 31'd300000000;
            4:       return 31'($urandom_range(0, 1200000000));
            5:       return 31'($urandom_range(0, 29999999));
            default: return 31'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [1:0]  k;
        logic [31:0] rnd;
        int          burst;
        #1 rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_report(KIND_OK, 32'h0);
        directed_report(KIND_FAIL, 32'h12345678);
        directed_report(KIND_FAIL, 32'h0);
        directed_report(KIND_RSVD, 32'h0);
        directed_report(KIND_ABORT, 32'hFFFFFFFF);
        directed_report(KIND_FAIL, 32'hFFFFFFFF);
        directed_report(KIND_FAIL, 32'd119998);
        directed_report(KIND_OK, 32'd119999);

        set_schedule(31'd0, 31'd0);
        directed_report(KIND_FAIL, 32'd5);
        directed_report(KIND_FAIL, 32'd5);
        directed_report(KIND_FAIL, 32'd5);
        directed_report(KIND_OK, 32'd5);

        set_schedule(31'd255, 31'h7FFFFFFF);
        directed_report(KIND_FAIL, 32'hAAAAAAAA);
        directed_report(KIND_FAIL, 32'h55555555);
        directed_report(KIND_ABORT, 32'h0);
        directed_report(KIND_OK, 32'hFFFFFFFF);

        set_schedule(31'h7FFFFF02, 31'd10000000);
        directed_report(KIND_FAIL, 32'd119998);
        directed_report(KIND_FAIL, 32'd119998);
        directed_report(KIND_FAIL, 32'd119998);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_schedule(pick_node(), pick_base());
            no_idle = (ph == 3);
            burst   = 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (burst == 0)
                begin
                    if (!no_idle)
                    begin
                        hold_off(($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                             : $urandom_range(0, 4));
                    end
                    burst = $urandom_range(1, 16);
                end
                if (ph == 1 && i == PHASE_ITEMS / 2)
                begin
                    drain_wakes();
                end
                pick_report(k, rnd);
                send_report(k, rnd);
                burst--;
            end
            no_idle = 1'b0;
        end

        drain_wakes();
        repeat (16) @(posedge clk);
        if (board.err_cnt == 0 && board.pending() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/wsbs_pkg.sv
rtl/wsbs_slot_mod.sv
rtl/wake_slot_backoff_scheduler.sv
rtl/wsbs_checker.sv
verif/tb.sv
